>>> sv/lte_pkg.sv
// Shared widths, codes, word types and helpers for the line trim/extend block.
`timescale 1ns / 1ps
`default_nettype none
package lte_pkg;

	// Coordinate and arithmetic widths
	localparam int CW   = 32;            // Q16.16 coordinate
	localparam int DW   = CW + 1;        // coordinate difference
	localparam int PW   = 2 * DW;        // product of two differences
	localparam int WW   = PW + 1;        // determinant and numerators
	localparam int MW   = 8;             // extend margin
	localparam int TW   = 16;            // parallel threshold
	localparam int FRAC = 24;            // margin scale, 2^-24
	localparam int EW   = WW + FRAC + 2; // extend compare width
	localparam int SLW  = WW + MW;       // determinant times margin
	localparam int LOW  = 34;            // low split of the numerator magnitude
	localparam int PLW  = LOW + DW;      // low partial product
	localparam int PHW  = WW - LOW + DW; // high partial product
	localparam int PRW  = WW + DW;       // full product magnitude
	localparam int NW   = PRW + 2;       // rounded dividend
	localparam int DVW  = WW + 1;        // doubled divisor
	localparam int QW   = 33;            // quotient bits
	localparam int SMW  = CW + 3;        // coordinate sum before clipping

	// Configuration port
	localparam int CFG_IW = 4;
	localparam logic [CFG_IW-1:0] REG_THRESHOLD = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_MARGIN    = CFG_IW'(1);

	localparam int QUEUE_DEPTH = 4;

	// Result status codes
	localparam logic [2:0] ST_DONE         = 3'd0;
	localparam logic [2:0] ST_NOT_ELIGIBLE = 3'd1;
	localparam logic [2:0] ST_PARALLEL     = 3'd2;
	localparam logic [2:0] ST_OUT_OF_RANGE = 3'd3;
	localparam logic [2:0] ST_NO_EXTEND    = 3'd4;

	typedef struct packed {
		logic                 req_type;
		logic                 not_eligible;
		logic signed [CW-1:0] cut_start_x;
		logic signed [CW-1:0] cut_start_y;
		logic signed [CW-1:0] cut_end_x;
		logic signed [CW-1:0] cut_end_y;
		logic signed [CW-1:0] tgt_start_x;
		logic signed [CW-1:0] tgt_start_y;
		logic signed [CW-1:0] tgt_end_x;
		logic signed [CW-1:0] tgt_end_y;
		logic signed [CW-1:0] pick_x;
		logic signed [CW-1:0] pick_y;
	} req_word_t;

	typedef struct packed {
		logic [2:0]           status;
		logic                 moved_end;
		logic                 saturated;
		logic signed [CW-1:0] new_start_x;
		logic signed [CW-1:0] new_start_y;
		logic signed [CW-1:0] new_end_x;
		logic signed [CW-1:0] new_end_y;
	} rsp_word_t;

	typedef struct packed {
		logic [CFG_IW-1:0] index;
		logic [TW-1:0]     value;
	} cfg_word_t;

	typedef struct packed {
		logic [TW-1:0] thr;
		logic [MW-1:0] margin;
	} cfg_regs_t;

	// Classified job handed from the front to the back
	typedef struct packed {
		logic [2:0]           status;
		logic                 use_end;
		logic [WW-1:0]        an1;
		logic                 n1_neg;
		logic [WW-1:0]        den;
		logic [DW-1:0]        fdx_mag;
		logic                 fdx_neg;
		logic [DW-1:0]        fdy_mag;
		logic                 fdy_neg;
		logic signed [CW-1:0] csx;
		logic signed [CW-1:0] csy;
		logic signed [CW-1:0] tsx;
		logic signed [CW-1:0] tsy;
		logic signed [CW-1:0] tex;
		logic signed [CW-1:0] tey;
	} job_t;

	function automatic logic signed [DW-1:0] diff(logic signed [CW-1:0] a,
			logic signed [CW-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	function automatic logic signed [PW-1:0] mul_s(logic signed [DW-1:0] a,
			logic signed [DW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

endpackage
`default_nettype wire

>>> sv/lte_chan_if.sv
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
`default_nettype none
interface lte_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/line_trim_extend.sv
// Top level of the line trim/extend block: config registers, front, queue and back.
// Takes one request word per cycle while req.ready is high and returns one result
// word per request, in order. The six-stage front computes the cross-product
// determinant and classifies the request; the back runs two 33-stage pipelined
// dividers for the rounded crossing point. A QUEUE_DEPTH-entry queue sits between
// the halves, so req.ready drops only when that queue is full and the last front
// stage holds a word. Config words are accepted every cycle and must only be
// written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module line_trim_extend #(
	parameter int QUEUE_DEPTH = lte_pkg::QUEUE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	lte_chan_if.sink   req,
	lte_chan_if.source rsp,
	lte_chan_if.sink   cfg
);
	import lte_pkg::*;

	cfg_regs_t cfg_q;

	lte_chan_if #(.T(job_t)) q_in ();
	lte_chan_if #(.T(job_t)) q_out ();

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_THRESHOLD: cfg_q.thr    <= cfg.data.value;
				REG_MARGIN:    cfg_q.margin <= cfg.data.value[MW-1:0];
				default: ;
			endcase
		end
	end

	lte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.req      (req),
		.job      (q_in)
	);

	lte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_in),
		.rd     (q_out)
	);

	lte_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (q_out),
		.rsp    (rsp)
	);

	// Request side stalls only behind a full queue
	a_ready_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (q_in.valid && !q_in.ready))
		else $error("request stalled while queue had room");

	// A failed request leaves the target untouched
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status != ST_DONE) |->
		(!rsp.data.moved_end && !rsp.data.saturated))
		else $error("failed result reports a move or clip");

	// Status stays within the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.status == ST_DONE || rsp.data.status == ST_NOT_ELIGIBLE ||
		rsp.data.status == ST_PARALLEL || rsp.data.status == ST_OUT_OF_RANGE ||
		rsp.data.status == ST_NO_EXTEND))
		else $error("undefined status code");
endmodule
`default_nettype wire

>>> sv/lte_front.sv
// Front half: takes request words, computes the determinant and classifies each word.
`timescale 1ns / 1ps
`default_nettype none
module lte_front (
	input  wire               clk,
	input  wire               arst_n,
	input  lte_pkg::cfg_regs_t cfg_regs,
	lte_chan_if.sink          req,
	lte_chan_if.source        job
);
	import lte_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: differences
	logic signed [DW-1:0] fdx_s1, fdy_s1, sdx_s1, sdy_s1, ox_s1, oy_s1;
	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic                 rt_s1, ne_s1;
	logic signed [CW-1:0] csx_s1, csy_s1, tsx_s1, tsy_s1, tex_s1, tey_s1;
	// Stage 2: products
	logic signed [PW-1:0] p_fs_s2, p_fs2_s2, p_on1a_s2, p_on1b_s2, p_on2a_s2, p_on2b_s2;
	logic signed [PW-1:0] p_ax_s2, p_ay_s2, p_bx_s2, p_by_s2;
	logic signed [DW-1:0] fdx_s2, fdy_s2;
	logic                 rt_s2, ne_s2;
	logic signed [CW-1:0] csx_s2, csy_s2, tsx_s2, tsy_s2, tex_s2, tey_s2;
	// Stage 3: determinant, numerators, squared distances
	logic signed [WW-1:0] den_s3, n1_s3, n2_s3, ds_s3, de_s3;
	logic signed [DW-1:0] fdx_s3, fdy_s3;
	logic                 rt_s3, ne_s3;
	logic signed [CW-1:0] csx_s3, csy_s3, tsx_s3, tsy_s3, tex_s3, tey_s3;
	// Stage 4: sign normalized
	logic signed [WW-1:0] den_s4, n1_s4, n2_s4;
	logic                 tend_s4;
	logic signed [DW-1:0] fdx_s4, fdy_s4;
	logic                 rt_s4, ne_s4;
	logic signed [CW-1:0] csx_s4, csy_s4, tsx_s4, tsy_s4, tex_s4, tey_s4;
	// Stage 5: margin product, magnitudes, parallel test
	logic [SLW-1:0]       slack_s5;
	logic signed [WW-1:0] den_s5, n1_s5, n2_s5;
	logic [WW-1:0]        an1_s5;
	logic                 n1neg_s5, par_s5, tend_s5;
	logic [DW-1:0]        fxm_s5, fym_s5;
	logic                 fxn_s5, fyn_s5;
	logic                 rt_s5, ne_s5;
	logic signed [CW-1:0] csx_s5, csy_s5, tsx_s5, tsy_s5, tex_s5, tey_s5;
	// Stage 6: classified job
	job_t                 job_s6;
	job_t                 job_c;

	// Advance unless the last stage holds a word the queue cannot take
	assign en        = !v_s6 || job.ready;
	assign req.ready = en;
	assign job.valid = v_s6;
	assign job.data  = job_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: line deltas and pick offsets
	always_ff @(posedge clk) begin
		if (en) begin
			fdx_s1 <= diff(req.data.cut_end_x, req.data.cut_start_x);
			fdy_s1 <= diff(req.data.cut_end_y, req.data.cut_start_y);
			sdx_s1 <= diff(req.data.tgt_end_x, req.data.tgt_start_x);
			sdy_s1 <= diff(req.data.tgt_end_y, req.data.tgt_start_y);
			ox_s1  <= diff(req.data.tgt_start_x, req.data.cut_start_x);
			oy_s1  <= diff(req.data.tgt_start_y, req.data.cut_start_y);
			ax_s1  <= diff(req.data.pick_x, req.data.tgt_start_x);
			ay_s1  <= diff(req.data.pick_y, req.data.tgt_start_y);
			bx_s1  <= diff(req.data.pick_x, req.data.tgt_end_x);
			by_s1  <= diff(req.data.pick_y, req.data.tgt_end_y);
			rt_s1  <= req.data.req_type;
			ne_s1  <= req.data.not_eligible;
			csx_s1 <= req.data.cut_start_x;
			csy_s1 <= req.data.cut_start_y;
			tsx_s1 <= req.data.tgt_start_x;
			tsy_s1 <= req.data.tgt_start_y;
			tex_s1 <= req.data.tgt_end_x;
			tey_s1 <= req.data.tgt_end_y;
		end
	end

	// Stage 2: cross products and squares
	always_ff @(posedge clk) begin
		if (en) begin
			p_fs_s2   <= mul_s(fdx_s1, sdy_s1);
			p_fs2_s2  <= mul_s(fdy_s1, sdx_s1);
			p_on1a_s2 <= mul_s(ox_s1, sdy_s1);
			p_on1b_s2 <= mul_s(oy_s1, sdx_s1);
			p_on2a_s2 <= mul_s(ox_s1, fdy_s1);
			p_on2b_s2 <= mul_s(oy_s1, fdx_s1);
			p_ax_s2   <= mul_s(ax_s1, ax_s1);
			p_ay_s2   <= mul_s(ay_s1, ay_s1);
			p_bx_s2   <= mul_s(bx_s1, bx_s1);
			p_by_s2   <= mul_s(by_s1, by_s1);
			fdx_s2    <= fdx_s1;
			fdy_s2    <= fdy_s1;
			rt_s2     <= rt_s1;
			ne_s2     <= ne_s1;
			csx_s2    <= csx_s1;
			csy_s2    <= csy_s1;
			tsx_s2    <= tsx_s1;
			tsy_s2    <= tsy_s1;
			tex_s2    <= tex_s1;
			tey_s2    <= tey_s1;
		end
	end

	// Stage 3: determinant and numerators
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= WW'(p_fs_s2) - WW'(p_fs2_s2);
			n1_s3  <= WW'(p_on1a_s2) - WW'(p_on1b_s2);
			n2_s3  <= WW'(p_on2a_s2) - WW'(p_on2b_s2);
			ds_s3  <= WW'(p_ax_s2) + WW'(p_ay_s2);
			de_s3  <= WW'(p_bx_s2) + WW'(p_by_s2);
			fdx_s3 <= fdx_s2;
			fdy_s3 <= fdy_s2;
			rt_s3  <= rt_s2;
			ne_s3  <= ne_s2;
			csx_s3 <= csx_s2;
			csy_s3 <= csy_s2;
			tsx_s3 <= tsx_s2;
			tsy_s3 <= tsy_s2;
			tex_s3 <= tex_s2;
			tey_s3 <= tey_s2;
		end
	end

	// Stage 4: make the determinant positive
	always_ff @(posedge clk) begin
		if (en) begin
			den_s4  <= den_s3[WW-1] ? -den_s3 : den_s3;
			n1_s4   <= den_s3[WW-1] ? -n1_s3 : n1_s3;
			n2_s4   <= den_s3[WW-1] ? -n2_s3 : n2_s3;
			tend_s4 <= ds_s3 > de_s3;
			fdx_s4  <= fdx_s3;
			fdy_s4  <= fdy_s3;
			rt_s4   <= rt_s3;
			ne_s4   <= ne_s3;
			csx_s4  <= csx_s3;
			csy_s4  <= csy_s3;
			tsx_s4  <= tsx_s3;
			tsy_s4  <= tsy_s3;
			tex_s4  <= tex_s3;
			tey_s4  <= tey_s3;
		end
	end

	// Stage 5: margin slack, parallel test, magnitudes for the back half
	always_ff @(posedge clk) begin
		if (en) begin
			slack_s5 <= SLW'($unsigned(den_s4)) * SLW'(cfg_regs.margin);
			par_s5   <= $unsigned(den_s4) <= WW'(cfg_regs.thr);
			den_s5   <= den_s4;
			n1_s5    <= n1_s4;
			n2_s5    <= n2_s4;
			an1_s5   <= n1_s4[WW-1] ? $unsigned(-n1_s4) : $unsigned(n1_s4);
			n1neg_s5 <= n1_s4[WW-1];
			fxm_s5   <= fdx_s4[DW-1] ? $unsigned(-fdx_s4) : $unsigned(fdx_s4);
			fxn_s5   <= fdx_s4[DW-1];
			fym_s5   <= fdy_s4[DW-1] ? $unsigned(-fdy_s4) : $unsigned(fdy_s4);
			fyn_s5   <= fdy_s4[DW-1];
			tend_s5  <= tend_s4;
			rt_s5    <= rt_s4;
			ne_s5    <= ne_s4;
			csx_s5   <= csx_s4;
			csy_s5   <= csy_s4;
			tsx_s5   <= tsx_s4;
			tsy_s5   <= tsy_s4;
			tex_s5   <= tex_s4;
			tey_s5   <= tey_s4;
		end
	end

	// Stage 6: range tests and status
	always_comb begin
		logic signed [EW-1:0] s1e, s2e, sle, hie;
		logic                 trim_oor;
		s1e = EW'(n1_s5) <<< FRAC;
		s2e = EW'(n2_s5) <<< FRAC;
		sle = $signed(EW'(slack_s5));
		hie = (EW'(den_s5) <<< FRAC) + sle;
		trim_oor = n1_s5[WW-1] || (n1_s5 > den_s5) || n2_s5[WW-1] || (n2_s5 > den_s5);

		job_c         = '0;
		job_c.an1     = an1_s5;
		job_c.n1_neg  = n1neg_s5;
		job_c.den     = $unsigned(den_s5);
		job_c.fdx_mag = fxm_s5;
		job_c.fdx_neg = fxn_s5;
		job_c.fdy_mag = fym_s5;
		job_c.fdy_neg = fyn_s5;
		job_c.csx     = csx_s5;
		job_c.csy     = csy_s5;
		job_c.tsx     = tsx_s5;
		job_c.tsy     = tsy_s5;
		job_c.tex     = tex_s5;
		job_c.tey     = tey_s5;
		job_c.status  = ST_DONE;
		job_c.use_end = 1'b0;
		if (ne_s5) begin
			job_c.status = ST_NOT_ELIGIBLE;
		end else if (par_s5) begin
			job_c.status = ST_PARALLEL;
		end else if (!rt_s5) begin
			if (trim_oor) begin
				job_c.status = ST_OUT_OF_RANGE;
			end else begin
				job_c.use_end = tend_s5;
			end
		end else begin
			if ((s1e + sle < 0) || (s1e > hie)) begin
				job_c.status = ST_OUT_OF_RANGE;
			end else if (s2e + sle < 0) begin
				job_c.use_end = 1'b0;
			end else if (s2e > hie) begin
				job_c.use_end = 1'b1;
			end else begin
				job_c.status = ST_NO_EXTEND;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s6 <= job_c;
		end
	end
endmodule
`default_nettype wire

>>> sv/lte_queue.sv
// Short queue of classified jobs between the front and back halves.
`timescale 1ns / 1ps
`default_nettype none
module lte_queue #(
	parameter int DEPTH = lte_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	lte_chan_if.sink    wr,
	lte_chan_if.source  rd
);
	import lte_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	job_t           mem [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CNW-1:0] cnt_q;
	logic           push, pop;

	assign wr.ready = cnt_q != CNW'(DEPTH);
	assign rd.valid = cnt_q != '0;
	assign rd.data  = mem[rp_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	// Store incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr.data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/lte_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module lte_div (
	input  wire                        clk,
	input  wire                        en,
	input  wire [lte_pkg::NW-1:0]      num,
	input  wire [lte_pkg::DVW-1:0]     dvs,
	output logic [lte_pkg::QW-1:0]     quo
);
	import lte_pkg::*;

	logic [NW-1:0]  rem_c [QW];
	logic [DVW-1:0] dvs_c [QW];
	logic [QW-1:0]  quo_c [QW+1];

	assign rem_c[0] = num;
	assign dvs_c[0] = dvs;
	assign quo_c[0] = '0;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [NW-1:0] shifted;
		logic          take;
		logic [QW-1:0] quo_r;

		// Try to subtract the divisor aligned to this quotient bit
		assign shifted = NW'(dvs_c[j]) << K;
		assign take    = rem_c[j] >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_r <= {quo_c[j][QW-2:0], take};
			end
		end
		assign quo_c[j+1] = quo_r;

		if (j < QW - 1) begin : g_pass
			logic [NW-1:0]  rem_r;
			logic [DVW-1:0] dvs_r;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_r <= take ? rem_c[j] - shifted : rem_c[j];
					dvs_r <= dvs_c[j];
				end
			end
			assign rem_c[j+1] = rem_r;
			assign dvs_c[j+1] = dvs_r;
		end
	end

	assign quo = quo_c[QW];
endmodule
`default_nettype wire

>>> sv/lte_back.sv
// Back half: computes the rounded crossing point and builds the result word.
`timescale 1ns / 1ps
`default_nettype none
module lte_back (
	input  wire        clk,
	input  wire        arst_n,
	lte_chan_if.sink   job,
	lte_chan_if.source rsp
);
	import lte_pkg::*;

	localparam int LAT = QW + 2;

	typedef struct packed {
		logic [2:0]           status;
		logic                 use_end;
		logic                 negx;
		logic                 negy;
		logic signed [CW-1:0] csx;
		logic signed [CW-1:0] csy;
		logic signed [CW-1:0] tsx;
		logic signed [CW-1:0] tsy;
		logic signed [CW-1:0] tex;
		logic signed [CW-1:0] tey;
	} meta_t;

	localparam logic signed [SMW-1:0] CMAX = SMW'(32'sh7fff_ffff);
	localparam logic signed [SMW-1:0] CMIN = SMW'(32'sh8000_0000);

	logic           en;
	logic           vld_q [LAT];
	meta_t          meta_q [LAT];
	meta_t          meta_in;
	logic [PLW-1:0] plx_b1, ply_b1;
	logic [PHW-1:0] phx_b1, phy_b1;
	logic [WW-1:0]  den_b1;
	logic [NW-1:0]  numx_b2, numy_b2;
	logic [DVW-1:0] dvs_b2;
	logic [QW-1:0]  qx, qy;
	logic           rsp_valid_q;
	rsp_word_t      rsp_data_q;
	rsp_word_t      rsp_c;

	// Add base to the signed quotient and clip to 32 bits; top bit flags a clip
	function automatic logic [CW:0] place(logic signed [CW-1:0] base,
			logic [QW-1:0] q, logic neg);
		logic signed [SMW-1:0] qs, s;
		qs = $signed(SMW'(q));
		if (neg) qs = -qs;
		s = SMW'(base) + qs;
		if (s > CMAX) return {1'b1, CMAX[CW-1:0]};
		if (s < CMIN) return {1'b1, CMIN[CW-1:0]};
		return {1'b0, s[CW-1:0]};
	endfunction

	// Hold everything while the result word waits
	assign en        = !rsp_valid_q || rsp.ready;
	assign job.ready = en;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_comb begin
		meta_in.status  = job.data.status;
		meta_in.use_end = job.data.use_end;
		meta_in.negx    = job.data.n1_neg ^ job.data.fdx_neg;
		meta_in.negy    = job.data.n1_neg ^ job.data.fdy_neg;
		meta_in.csx     = job.data.csx;
		meta_in.csy     = job.data.csy;
		meta_in.tsx     = job.data.tsx;
		meta_in.tsy     = job.data.tsy;
		meta_in.tex     = job.data.tex;
		meta_in.tey     = job.data.tey;
	end

	// Valid and side data follow the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= job.valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
			rsp_valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0] <= meta_in;
			for (int i = 1; i < LAT; i++) meta_q[i] <= meta_q[i-1];
		end
	end

	// Stage 1: partial products of the numerator magnitude and the deltas
	always_ff @(posedge clk) begin
		if (en) begin
			plx_b1 <= PLW'(job.data.an1[LOW-1:0]) * PLW'(job.data.fdx_mag);
			phx_b1 <= PHW'(job.data.an1[WW-1:LOW]) * PHW'(job.data.fdx_mag);
			ply_b1 <= PLW'(job.data.an1[LOW-1:0]) * PLW'(job.data.fdy_mag);
			phy_b1 <= PHW'(job.data.an1[WW-1:LOW]) * PHW'(job.data.fdy_mag);
			den_b1 <= job.data.den;
		end
	end

	// Stage 2: rounding dividend 2|p| + den over divisor 2 den
	always_ff @(posedge clk) begin
		if (en) begin
			numx_b2 <= (NW'(phx_b1) << (LOW + 1)) + (NW'(plx_b1) << 1) + NW'(den_b1);
			numy_b2 <= (NW'(phy_b1) << (LOW + 1)) + (NW'(ply_b1) << 1) + NW'(den_b1);
			dvs_b2  <= {den_b1, 1'b0};
		end
	end

	lte_div u_div_x (.clk(clk), .en(en), .num(numx_b2), .dvs(dvs_b2), .quo(qx));
	lte_div u_div_y (.clk(clk), .en(en), .num(numy_b2), .dvs(dvs_b2), .quo(qy));

	// Build the result word
	always_comb begin
		logic [CW:0] px, py;
		meta_t       m;
		m  = meta_q[LAT-1];
		px = place(m.csx, qx, m.negx);
		py = place(m.csy, qy, m.negy);
		rsp_c.status      = m.status;
		rsp_c.moved_end   = 1'b0;
		rsp_c.saturated   = 1'b0;
		rsp_c.new_start_x = m.tsx;
		rsp_c.new_start_y = m.tsy;
		rsp_c.new_end_x   = m.tex;
		rsp_c.new_end_y   = m.tey;
		if (m.status == ST_DONE) begin
			rsp_c.saturated = px[CW] | py[CW];
			if (m.use_end) begin
				rsp_c.moved_end = 1'b1;
				rsp_c.new_end_x = $signed(px[CW-1:0]);
				rsp_c.new_end_y = $signed(py[CW-1:0]);
			end else begin
				rsp_c.new_start_x = $signed(px[CW-1:0]);
				rsp_c.new_start_y = $signed(py[CW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_data_q <= rsp_c;
		end
	end
endmodule
`default_nettype wire

>>> bench/tb_line_trim_extend.sv
// Self-checking bench for the line trim/extend block: directed table, then random pairs.
`timescale 1ns / 1ps
module tb_line_trim_extend;
	import lte_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

	typedef struct {
		req_word_t w;
		logic      has_exp;
		rsp_word_t e;
	} table_row_t;

	logic clk;
	logic arst_n;

	lte_chan_if #(.T(req_word_t)) req_ch ();
	lte_chan_if #(.T(rsp_word_t)) rsp_ch ();
	lte_chan_if #(.T(cfg_word_t)) cfg_ch ();

	line_trim_extend u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	rsp_word_t  pending_rsp[$];
	int         errors = 0;
	int         idle_cycles = 0;
	idle_mode_t idle_mode = IDLE_NONE;
	logic       hold_off = 1'b0;
	logic [TW-1:0] thr_shadow = '0;
	logic [MW-1:0] margin_shadow = '0;
	table_row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Exact crossing coordinate: base + num*delta/den, rounded half away, clipped
	function automatic logic signed [CW-1:0] crossing_coord(logic signed [CW-1:0] base,
			logic signed [DW-1:0] delta, logic signed [127:0] num,
			logic signed [127:0] den, ref logic sat);
		logic signed [191:0] prod;
		logic [191:0] mag;
		logic [191:0] quo;
		logic signed [191:0] sum;
		prod = 192'(num) * 192'(delta);
		mag = prod < 0 ? -prod : prod;
		quo = (2 * mag + 192'(den)) / (2 * 192'(den));
		sum = (prod < 0 ? -$signed(quo) : $signed(quo)) + 192'(base);
		if (sum > 192'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (sum < -192'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return sum[CW-1:0];
	endfunction

	// Predict the trimmed or extended line for one request word
	function automatic rsp_word_t trim_extend_line(req_word_t w);
		logic signed [127:0] fdx, fdy, sdx, sdy, ox, oy, den, n1, n2, aden;
		logic signed [127:0] ds, de, slack, hi, s1, s2;
		logic signed [CW-1:0] ix, iy;
		logic use_end, sat;
		rsp_word_t r;
		fdx = 128'(w.cut_end_x) - 128'(w.cut_start_x);
		fdy = 128'(w.cut_end_y) - 128'(w.cut_start_y);
		sdx = 128'(w.tgt_end_x) - 128'(w.tgt_start_x);
		sdy = 128'(w.tgt_end_y) - 128'(w.tgt_start_y);
		ox = 128'(w.tgt_start_x) - 128'(w.cut_start_x);
		oy = 128'(w.tgt_start_y) - 128'(w.cut_start_y);
		den = fdx * sdy - fdy * sdx;
		n1 = ox * sdy - oy * sdx;
		n2 = ox * fdy - oy * fdx;
		aden = den < 0 ? -den : den;
		r = '0;
		r.new_start_x = w.tgt_start_x;
		r.new_start_y = w.tgt_start_y;
		r.new_end_x = w.tgt_end_x;
		r.new_end_y = w.tgt_end_y;
		use_end = 1'b0;
		sat = 1'b0;
		if (w.not_eligible) begin
			r.status = ST_NOT_ELIGIBLE;
			return r;
		end
		if (aden <= 128'(thr_shadow)) begin
			r.status = ST_PARALLEL;
			return r;
		end
		if (den < 0) begin
			den = -den;
			n1 = -n1;
			n2 = -n2;
		end
		r.status = ST_DONE;
		if (!w.req_type) begin
			if (n1 < 0 || n1 > den || n2 < 0 || n2 > den) begin
				r.status = ST_OUT_OF_RANGE;
			end else begin
				ds = (128'(w.pick_x) - 128'(w.tgt_start_x)) ** 2
					+ (128'(w.pick_y) - 128'(w.tgt_start_y)) ** 2;
				de = (128'(w.pick_x) - 128'(w.tgt_end_x)) ** 2
					+ (128'(w.pick_y) - 128'(w.tgt_end_y)) ** 2;
				use_end = ds > de;
			end
		end else begin
			slack = den * 128'(margin_shadow);
			hi = den * (128'(1 << FRAC) + 128'(margin_shadow));
			s1 = n1 <<< FRAC;
			s2 = n2 <<< FRAC;
			if (s1 + slack < 0 || s1 > hi) r.status = ST_OUT_OF_RANGE;
			else if (s2 + slack < 0) use_end = 1'b0;
			else if (s2 > hi) use_end = 1'b1;
			else r.status = ST_NO_EXTEND;
		end
		if (r.status != ST_DONE) return r;
		ix = crossing_coord(w.cut_start_x, DW'(fdx), n1, den, sat);
		iy = crossing_coord(w.cut_start_y, DW'(fdy), n1, den, sat);
		r.saturated = sat;
		r.moved_end = use_end;
		if (use_end) begin
			r.new_end_x = ix;
			r.new_end_y = iy;
		end else begin
			r.new_start_x = ix;
			r.new_start_y = iy;
		end
		return r;
	endfunction

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Drive receiver ready from the idling mode
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_off) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_SNK: rsp_ch.ready <= ($urandom_range(99) >= 53);
				IDLE_BOTH: rsp_ch.ready <= ($urandom_range(99) >= 7);
				default: rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		rsp_word_t e;
		rsp_word_t a;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			a = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result word %p", a);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (a.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, a.status);
					errors++;
				end
				if (a.moved_end !== e.moved_end) begin
					$error("moved_end exp %0d got %0d", e.moved_end, a.moved_end);
					errors++;
				end
				if (a.saturated !== e.saturated) begin
					$error("saturated exp %0d got %0d", e.saturated, a.saturated);
					errors++;
				end
				if (a.new_start_x !== e.new_start_x) begin
					$error("new_start_x exp %h got %h", e.new_start_x, a.new_start_x);
					errors++;
				end
				if (a.new_start_y !== e.new_start_y) begin
					$error("new_start_y exp %h got %h", e.new_start_y, a.new_start_y);
					errors++;
				end
				if (a.new_end_x !== e.new_end_x) begin
					$error("new_end_x exp %h got %h", e.new_end_x, a.new_end_x);
					errors++;
				end
				if (a.new_end_y !== e.new_end_y) begin
					$error("new_end_y exp %h got %h", e.new_end_y, a.new_end_y);
					errors++;
				end
			end
		end
	end

	// Offer one request word and hold it until accepted; valid stays up for the next word
	task automatic send_req(req_word_t w, logic has_exp, rsp_word_t e);
		if (idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) begin
			while ($urandom_range(99) < (idle_mode == IDLE_SRC ? 53 : 7)) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		pending_rsp.insert(pending_rsp.size(), has_exp ? e : trim_extend_line(w));
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [TW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, value: val};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_THRESHOLD) thr_shadow = val;
		else margin_shadow = val[MW-1:0];
		@(posedge clk);
	endtask

	// Drain outstanding results, then let the pipeline settle
	task automatic drain();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(int sel);
		case (sel)
			0: return $signed($urandom());
			1: return $signed(CW'($urandom_range(2000)) - CW'(1000)) <<< 16;
			2: return $signed(CW'($urandom_range(65535)) - CW'(32768));
			default: return $signed(CW'($urandom_range(200000)) - CW'(100000)) <<< 12;
		endcase
	endfunction

	// Random pair: mostly crossing lines at modest scale, some wide noise
	function automatic req_word_t rand_req();
		req_word_t w;
		int sel;
		logic signed [CW-1:0] cx, cy;
		w = '0;
		sel = $urandom_range(9) == 0 ? 0 : $urandom_range(3) + 0;
		if (sel == 0 && $urandom_range(1)) sel = 1;
		w.req_type = 1'($urandom_range(1));
		w.not_eligible = ($urandom_range(19) == 0);
		w.cut_start_x = rand_coord(sel);
		w.cut_start_y = rand_coord(sel);
		w.cut_end_x = rand_coord(sel);
		w.cut_end_y = rand_coord(sel);
		w.tgt_start_x = rand_coord(sel);
		w.tgt_start_y = rand_coord(sel);
		w.tgt_end_x = rand_coord(sel);
		w.tgt_end_y = rand_coord(sel);
		w.pick_x = rand_coord(sel);
		w.pick_y = rand_coord(sel);
		// parallel or degenerate target, or a very short cut line, now and then
		case ($urandom_range(15))
			0: begin
				w.tgt_end_x = w.tgt_start_x + (w.cut_end_x - w.cut_start_x);
				w.tgt_end_y = w.tgt_start_y + (w.cut_end_y - w.cut_start_y);
			end
			1: begin
				w.tgt_end_x = w.tgt_start_x;
				w.tgt_end_y = w.tgt_start_y;
			end
			2: begin
				cx = w.cut_start_x;
				cy = w.cut_start_y;
				w.cut_end_x = cx + CW'($urandom_range(3));
				w.cut_end_y = cy + CW'($urandom_range(3));
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic req_word_t mk(logic rt, logic ne, int csx, int csy, int cex,
			int cey, int tsx, int tsy, int tex, int tey, int px, int py);
		return '{rt, ne, csx, csy, cex, cey, tsx, tsy, tex, tey, px, py};
	endfunction

	function automatic rsp_word_t unchanged(req_word_t w, logic [2:0] st);
		return '{st, 1'b0, 1'b0, w.tgt_start_x, w.tgt_start_y, w.tgt_end_x, w.tgt_end_y};
	endfunction

	localparam int ONE = 32'h0001_0000;
	localparam int MAXC = 32'h7fff_ffff;
	localparam int MINC = 32'h8000_0000;

	initial begin
		req_word_t w;
		rsp_word_t none;
		int n;
		none = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: expectations typed in where obvious
		w = mk(0, 1, 0, 0, ONE, 0, 0, -ONE, 0, ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_NOT_ELIGIBLE)});
		w = mk(0, 0, 0, 0, ONE, 0, 0, ONE, ONE, ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_PARALLEL)});
		w = mk(1, 0, 5, 5, 5, 5, 0, 0, ONE, ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_PARALLEL)});
		w = mk(0, 0, -ONE, 0, ONE, 0, 0, -ONE, 0, ONE, 0, ONE);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, '{ST_DONE, 1'b1, 1'b0, 0, -ONE, 0, 0}});
		w = mk(0, 0, -ONE, 0, ONE, 0, 0, -ONE, 0, ONE, 0, -ONE);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, '{ST_DONE, 1'b0, 1'b0, 0, 0, 0, ONE}});
		w = mk(0, 0, -ONE, 0, ONE, 0, 0, -ONE, 0, ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b0, none});
		w = mk(0, 0, -ONE, 0, ONE, 0, 0, ONE, 0, 3 * ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_OUT_OF_RANGE)});
		w = mk(1, 0, -ONE, 0, ONE, 0, 0, ONE, 0, 3 * ONE, 0, 0);
		dir_rows.insert(dir_rows.size(),
			'{w, 1'b1, '{ST_DONE, 1'b0, 1'b0, 0, 0, 0, 3 * ONE}});
		w = mk(1, 0, -ONE, 0, ONE, 0, 0, -3 * ONE, 0, -ONE, 0, 0);
		dir_rows.insert(dir_rows.size(),
			'{w, 1'b1, '{ST_DONE, 1'b1, 1'b0, 0, -3 * ONE, 0, 0}});
		w = mk(1, 0, -ONE, 0, ONE, 0, 0, -ONE, 0, ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_NO_EXTEND)});
		w = mk(1, 0, ONE, 0, 2 * ONE, 0, 0, ONE, 0, 3 * ONE, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_OUT_OF_RANGE)});
		w = mk(1, 0, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC - 1, MINC + 1, 0, 0);
		dir_rows.insert(dir_rows.size(), '{w, 1'b0, none});
		w = mk(0, 0, MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC);
		dir_rows.insert(dir_rows.size(), '{w, 1'b0, none});
		w = mk(1, 0, MINC, 0, MAXC, 1, 0, MINC, 1, MINC + 2, MINC, MINC);
		dir_rows.insert(dir_rows.size(), '{w, 1'b0, none});
		w = mk(0, 0, 0, 0, 3, 0, 1, -1, 1, 1, -1, -1);
		dir_rows.insert(dir_rows.size(), '{w, 1'b0, none});
		w = mk(1, 1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
		dir_rows.insert(dir_rows.size(), '{w, 1'b1, unchanged(w, ST_NOT_ELIGIBLE)});
		foreach (dir_rows[i]) send_req(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].e);
		req_ch.valid <= 1'b0;
		drain();

		// Threshold and margin at their extremes, near-edge cases for margin
		write_reg(REG_THRESHOLD, 16'hffff);
		write_reg(REG_MARGIN, 8'hff);
		send_req(mk(0, 0, 0, 0, 255, 0, 0, 0, 0, 255, 0, 0), 1'b0, none);
		send_req(mk(0, 0, 0, 0, 257, 0, 0, 0, 0, 257, 0, 0), 1'b0, none);
		send_req(mk(1, 0, 0, 0, ONE, 0, ONE + 1, -ONE, ONE + 1, -2, 0, 0), 1'b0, none);
		send_req(mk(1, 0, 0, 0, ONE, 0, -2, -ONE, -2, -5, 0, 0), 1'b0, none);
		req_ch.valid <= 1'b0;
		drain();

		// Random phases across settings and idling modes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_mode = IDLE_NONE;
				1: idle_mode = IDLE_SRC;
				2: idle_mode = IDLE_SNK;
				default: idle_mode = IDLE_BOTH;
			endcase
			case (ph)
				0: write_reg(REG_THRESHOLD, 16'h0000);
				3: write_reg(REG_THRESHOLD, 16'hffff);
				default: write_reg(REG_THRESHOLD, TW'($urandom_range(65535)));
			endcase
			case (ph)
				0: write_reg(REG_MARGIN, 8'h00);
				3: write_reg(REG_MARGIN, 8'hff);
				default: write_reg(REG_MARGIN, TW'($urandom_range(255)));
			endcase
			n = 0;
			while (n < 200) begin
				send_req(rand_req(), 1'b0, none);
				n++;
			end
			req_ch.valid <= 1'b0;
			drain();
		end

		// Long receiver hold-off while requests keep coming
		idle_mode = IDLE_NONE;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 120; i++) send_req(rand_req(), 1'b0, none);
				req_ch.valid <= 1'b0;
			end
		join
		drain();

		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
